@@ hw/rtl/sha1md_pkg.sv @@
// shared types, constants and helpers for the sha-1 message digest block
// no dependencies; imported by the controller, the datapath and the top level
package sha1md_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NumH   = 5;
  localparam int unsigned Rounds = 80;

  localparam logic [ByteW-1:0] PadByte = 8'h80;

  localparam logic [WordW-1:0] InitH [NumH] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  localparam logic [6:0] LastRound = 7'd79;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    BSEL_IN,
    BSEL_PAD80,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic      byte_we;    // push one byte into the block
    logic      len_inc;    // byte belongs to the message
    byte_sel_t byte_sel;
    logic      load_work;  // copy chain words into work words
    logic      round;      // run one compression round
    logic      add;        // fold work words into chain words
    logic      out_shift;  // digest word taken, move to next
    logic      out_done;   // last digest word taken, back to initial values
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic cnt_full;    // byte count is 63
    logic cnt_at55;    // next byte lands at 55, length follows
    logic round_last;  // round 79
    logic out_last;    // fifth digest word on the output
  } sts_t;

  function automatic logic [WordW-1:0] round_k(input logic [6:0] t);
    logic [WordW-1:0] k;
    if (t < 7'd20)      k = K0;
    else if (t < 7'd40) k = K1;
    else if (t < 7'd60) k = K2;
    else                k = K3;
    return k;
  endfunction

endpackage

@@ hw/rtl/sha1md_ctrl.sv @@
// controller state machine for the sha-1 message digest block
// depends on sha1md_pkg; drives the datapath through cmd_t, reads sts_t
module sha1md_ctrl
  import sha1md_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_tvalid,
  output logic   in_tready,
  input  logic   in_tlast,
  input  logic   in_tuser,
  output logic   out_tvalid,
  input  logic   out_tready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  state_t pad_next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    pad_next   = sts.cnt_at55 ? ST_PADLEN : ST_PADZ;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser) begin
            cmd.byte_we  = 1'b1;
            cmd.len_inc  = 1'b1;
            cmd.byte_sel = BSEL_IN;
          end
          if (in_tuser && sts.cnt_full) begin
            cmd.load_work = 1'b1;
            state_nxt     = ST_COMP;
            ret_nxt       = in_tlast ? ST_PAD80 : ST_IDLE;
          end else begin
            state_nxt = in_tlast ? ST_PAD80 : ST_IDLE;
          end
        end
      end
      ST_PAD80, ST_PADZ: begin
        cmd.byte_we  = 1'b1;
        cmd.byte_sel = (state_r == ST_PAD80) ? BSEL_PAD80 : BSEL_ZERO;
        if (sts.cnt_full) begin
          cmd.load_work = 1'b1;
          state_nxt     = ST_COMP;
          ret_nxt       = pad_next;
        end else begin
          state_nxt = pad_next;
        end
      end
      ST_PADLEN: begin
        cmd.byte_we  = 1'b1;
        cmd.byte_sel = BSEL_LEN;
        if (sts.cnt_full) begin
          cmd.load_work = 1'b1;
          state_nxt     = ST_COMP;
          ret_nxt       = ST_OUT;
        end
      end
      ST_COMP: begin
        cmd.round = 1'b1;
        if (sts.round_last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ret_r;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.out_shift = 1'b1;
          if (sts.out_last) begin
            cmd.out_done = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while digest is on the output");

  a_round_then_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && sts.round_last) |=> (state_r == ST_ADD))
    else $error("final round not followed by chain update");

  a_last_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && sts.out_last) |=> (state_r == ST_IDLE && in_tready))
    else $error("block not ready for a new message after the last digest word");

endmodule

@@ hw/rtl/sha1md_dp.sv @@
// datapath for the sha-1 message digest block: byte packer, schedule shift line,
// round logic, chain words, byte count and bit length; depends on sha1md_pkg
module sha1md_dp
  import sha1md_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ByteW-1:0] in_byte,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic [WordW-1:0] out_word
);

  logic [WordW-1:0] chain_r [NumH];
  logic [WordW-1:0] work_r  [NumH];
  logic [WordW-1:0] win_r   [16];
  logic [23:0]      pack_r;
  logic [5:0]       cnt_r;
  logic [63:0]      len_r;
  logic [6:0]       rnd_r;
  logic [2:0]       oidx_r;

  logic [ByteW-1:0] byte_mux;
  logic [63:0]      len_sh;
  logic [WordW-1:0] word_full;
  logic [WordW-1:0] w_x;
  logic [WordW-1:0] w_cur;
  logic [WordW-1:0] f_val;
  logic [WordW-1:0] tmp;

  assign len_sh    = len_r >> {~cnt_r[2:0], 3'b000};
  assign word_full = {pack_r, byte_mux};
  assign w_x       = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_cur     = (rnd_r < 7'd16) ? win_r[0] : {w_x[30:0], w_x[31]};

  always_comb begin
    unique case (cmd.byte_sel)
      BSEL_IN:    byte_mux = in_byte;
      BSEL_PAD80: byte_mux = PadByte;
      BSEL_ZERO:  byte_mux = '0;
      BSEL_LEN:   byte_mux = len_sh[7:0];
      default:    byte_mux = '0;
    endcase
  end

  always_comb begin
    if (rnd_r < 7'd20) begin
      f_val = (work_r[1] & work_r[2]) | (~work_r[1] & work_r[3]);
    end else if (rnd_r < 7'd40 || rnd_r >= 7'd60) begin
      f_val = work_r[1] ^ work_r[2] ^ work_r[3];
    end else begin
      f_val = (work_r[1] & work_r[2]) | (work_r[1] & work_r[3]) | (work_r[2] & work_r[3]);
    end
  end

  assign tmp = {work_r[0][26:0], work_r[0][31:27]} + f_val + work_r[4]
             + round_k(rnd_r) + w_cur;

  // control counters and chain words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      len_r  <= '0;
      rnd_r  <= '0;
      oidx_r <= '0;
      for (int i = 0; i < NumH; i++) chain_r[i] <= InitH[i];
    end else begin
      if (cmd.byte_we) cnt_r <= cnt_r + 6'd1;
      if (cmd.len_inc) len_r <= len_r + 64'd8;
      if (cmd.round) rnd_r <= (rnd_r == LastRound) ? 7'd0 : rnd_r + 7'd1;
      if (cmd.add) begin
        for (int i = 0; i < NumH; i++) chain_r[i] <= chain_r[i] + work_r[i];
      end
      if (cmd.out_done) begin
        len_r  <= '0;
        oidx_r <= '0;
        for (int i = 0; i < NumH; i++) chain_r[i] <= InitH[i];
      end else if (cmd.out_shift) begin
        oidx_r <= oidx_r + 3'd1;
        for (int i = 0; i < NumH - 1; i++) chain_r[i] <= chain_r[i+1];
      end
    end
  end

  // payload: packer, schedule shift line, work words
  always_ff @(posedge clk) begin
    if (cmd.byte_we) begin
      pack_r <= {pack_r[15:0], byte_mux};
    end
    if (cmd.byte_we && cnt_r[1:0] == 2'd3) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= word_full;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= w_cur;
    end
    if (cmd.load_work) begin
      for (int i = 0; i < NumH; i++) work_r[i] <= chain_r[i];
    end else if (cmd.round) begin
      work_r[4] <= work_r[3];
      work_r[3] <= work_r[2];
      work_r[2] <= {work_r[1][1:0], work_r[1][31:2]};
      work_r[1] <= work_r[0];
      work_r[0] <= tmp;
    end
  end

  assign sts.cnt_full   = (cnt_r == 6'd63);
  assign sts.cnt_at55   = (cnt_r == 6'd55);
  assign sts.round_last = (rnd_r == LastRound);
  assign sts.out_last   = (oidx_r == 3'(NumH - 1));
  assign out_word       = chain_r[0];

endmodule

@@ hw/rtl/sha1_message_digest.sv @@
// sha-1 message digest, top level: stream ports, controller and datapath
// depends on sha1md_pkg, sha1md_ctrl and sha1md_dp
//
// a byte without the end mark is taken while the block is idle; the byte that fills a 64-byte
// block stalls the input while the single round unit runs 80 rounds, then one chain add
// on the end mark the padding bytes go through the same byte path, one per cycle while no
// block is compressed: 9 to 72 bytes, one or two compressions, then five digest words, one
// per cycle while out_tready is high; no input is taken until the fifth word is taken
// reset (rst_n low, synchronous) loads the initial chain values and clears counters
module sha1_message_digest
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // last_word
);

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: byte intake, padding phases, round loop, digest output
  sha1md_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: block words shift in four bytes at a time, rounds reuse the same line
  sha1md_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_tdata)
  );

  // fifth word of the digest carries the last mark
  assign out_tlast = sts.out_last;

endmodule
